@@ sv/mbe_pkg.sv @@
// Shared types, constants and helper functions for the escape-time engine.
// No dependencies; every other file imports this package.
package mbe_pkg;

    // Field widths
    localparam int COL_W       = 13;
    localparam int IDX_W       = 26;
    localparam int COUNT_W     = 8;
    localparam int WIDTH_REG_W = 14;
    localparam int ITER_REG_W  = 9;
    localparam int DATA_W      = 14;

    // Fixed point: Q4.28 coordinates, Q8.56 products
    localparam int Q_W    = 32;
    localparam int PROD_W = 64;
    localparam int FRAC   = 28;

    // Mapping numerators: col * (13 << 26) and row * (5 << 27)
    localparam int NUM_W     = 43;
    localparam int RE_MULT   = 13;
    localparam int RE_SHIFT  = 26;
    localparam int IM_MULT   = 5;
    localparam int IM_SHIFT  = 27;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // Width of intermediate sums ahead of saturation
    localparam int SAT_W = NUM_W + 1;

    localparam logic signed [Q_W-1:0] RE_OFFSET = 32'sd536870912;
    localparam logic signed [Q_W-1:0] IM_OFFSET = 32'sd335544320;
    localparam logic [PROD_W-1:0]     ESCAPE_SQ = 64'h0400_0000_0000_0000;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 14'd1024;
    localparam logic [ITER_REG_W-1:0]  ITER_RESET  = 9'd256;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH = 1'b0,
        REG_ITER_CAP    = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_SQ_X,
        ST_SQ_Y,
        ST_CROSS,
        ST_UPDATE,
        ST_DONE
    } mbe_state_t;

    // Clamp to the Q4.28 range: in range when all bits above bit 31 match the sign
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (&v[SAT_W-1:Q_W-1] || ~|v[SAT_W-1:Q_W-1])
            r = v[Q_W-1:0];
        else if (v[SAT_W-1])
            r = {1'b1, {(Q_W-1){1'b0}}};
        else
            r = {1'b0, {(Q_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] re_numer(input logic [COL_W-1:0] col);
        return (NUM_W'(col) * NUM_W'(RE_MULT)) << RE_SHIFT;
    endfunction

    function automatic logic [NUM_W-1:0] im_numer(input logic [COL_W-1:0] row);
        return (NUM_W'(row) * NUM_W'(IM_MULT)) << IM_SHIFT;
    endfunction

endpackage

@@ sv/mbe_ifs.sv @@
// Valid/ready channel interfaces for pixel items and result items.
// Depends on mbe_pkg for the field widths.
interface mbe_pix_if;
    import mbe_pkg::*;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] pixel_col;
    logic [COL_W-1:0] pixel_row;
    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_res_if;
    import mbe_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   pixel_index;
    logic [COUNT_W-1:0] escape_count;
    modport source (output valid, output pixel_index, output escape_count, input ready);
    modport sink   (input valid, input pixel_index, input escape_count, output ready);
endinterface

@@ sv/mbe_div.sv @@
// Restoring divider, one quotient bit per cycle, for the coordinate mapping.
// Depends on mbe_pkg for the numerator width.
module mbe_div #(
    parameter int DEN_W = 14
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mbe_pkg::NUM_W-1:0] num,
    input  logic [DEN_W-1:0]         den,
    output logic                     done,
    output logic [mbe_pkg::NUM_W-1:0] quo
);
    import mbe_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic [DEN_W:0]       trial;
    logic                 qbit;
    logic [DEN_W:0]       diff;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            // Shift the numerator out at the top, the quotient in at the bottom
            num_reg <= {num_reg[NUM_W-2:0], qbit};
            rem_reg <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

@@ sv/mbe_mul.sv @@
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbe_pkg for the operand and product widths.
module mbe_mul (
    input  logic                             clk,
    input  logic signed [mbe_pkg::Q_W-1:0]    a,
    input  logic signed [mbe_pkg::Q_W-1:0]    b,
    output logic signed [mbe_pkg::PROD_W-1:0] prod
);
    import mbe_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ sv/mandelbrot_escape_time.sv @@
// Escape-time engine: one pixel item in, one result item out, on one shared multiplier.
// Steps are two coordinate divisions (43 quotient bits each), then per iteration the
// states ST_SQ_X, ST_SQ_Y, ST_CROSS and ST_UPDATE until the limit n is reached or
// the point escapes; ST_DONE then loads the output register.
// One item is worked on at a time; the next item is taken while a result waits.
// Reset (rst_n, async, active low): image_width = 1024, iteration cap = 256, idle.
module mandelbrot_escape_time #(
    parameter int MAX_DIM    = 8192,
    parameter int ITER_LIMIT = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mbe_pix_if.sink                     pix,
    mbe_res_if.source                   res,
    input  logic                        wr_en,
    input  mbe_pkg::reg_index_t         wr_index,
    input  logic [mbe_pkg::DATA_W-1:0]  wr_data
);
    import mbe_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // Configuration
    logic [WIDTH_REG_W-1:0] image_width_reg;
    logic [ITER_REG_W-1:0]  iter_cap_reg;

    // Sequencer and datapath
    mbe_state_t              state_reg, state_next;
    logic [COL_W-1:0]        col_reg;
    logic [COL_W-1:0]        row_reg;
    logic [DIM_W-1:0]        w_reg;
    logic [ITER_REG_W-1:0]   lim_reg;
    logic [ITER_REG_W-1:0]   it_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [Q_W-1:0]   c_re_reg;
    logic signed [Q_W-1:0]   c_im_reg;
    logic signed [Q_W-1:0]   x_reg;
    logic signed [Q_W-1:0]   y_reg;
    logic signed [PROD_W-1:0] xx_reg;
    logic signed [PROD_W-1:0] diff_reg;

    // Output register
    logic                    res_valid_reg;
    logic [IDX_W-1:0]        res_index_reg;
    logic [COUNT_W-1:0]      res_count_reg;

    logic [DIM_W-1:0]        w_eff;
    logic [ITER_REG_W-1:0]   lim_eff;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quo;
    logic signed [Q_W-1:0]   mul_a;
    logic signed [Q_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                    escaped;
    logic signed [SAT_W-1:0] re_sum;
    logic signed [SAT_W-1:0] im_sum;
    logic signed [SAT_W-1:0] q_ext;
    logic [ITER_REG_W-1:0]   it_inc;
    logic                    load_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_RESET;
            iter_cap_reg    <= ITER_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_IMAGE_WIDTH: image_width_reg <= wr_data[WIDTH_REG_W-1:0];
                REG_ITER_CAP:    iter_cap_reg    <= ITER_REG_W'(wr_data);
                default:         ;
            endcase
        end
    end

    // Width of zero counts as one; clamp width and limit to their maxima
    always_comb
    begin
        if (32'(image_width_reg) > MAX_DIM)
            w_eff = DIM_W'(MAX_DIM);
        else if (image_width_reg == '0)
            w_eff = DIM_W'(1);
        else
            w_eff = DIM_W'(image_width_reg);

        if (32'(iter_cap_reg) > ITER_LIMIT)
            lim_eff = ITER_REG_W'(ITER_LIMIT);
        else
            lim_eff = iter_cap_reg;
    end

    mbe_div #(
        .DEN_W (DIM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (state_reg == ST_IDLE ? w_eff : w_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    mbe_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        q_ext   = $signed({1'b0, div_quo});
        escaped = ($unsigned(xx_reg) + $unsigned(prod)) > ESCAPE_SQ;
        re_sum  = SAT_W'(diff_reg >>> FRAC) + SAT_W'(c_re_reg);
        im_sum  = SAT_W'(prod >>> (FRAC - 1)) + SAT_W'(c_im_reg);
        it_inc  = it_reg + 1'b1;
        load_res = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = im_numer(row_reg);
        // Row times width runs while the divider is busy
        mul_a      = $signed(Q_W'(row_reg));
        mul_b      = $signed(Q_W'(w_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                div_num = re_numer(pix.pixel_col);
                if (pix.valid)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_RE;
                end
            end
            ST_DIV_RE:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_IM;
                end
            end
            ST_DIV_IM:
            begin
                if (div_done)
                    state_next = (lim_reg == '0) ? ST_DONE : ST_SQ_X;
            end
            ST_SQ_X:
            begin
                mul_a      = x_reg;
                mul_b      = x_reg;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                mul_a      = y_reg;
                mul_b      = y_reg;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                mul_a      = x_reg;
                mul_b      = y_reg;
                state_next = escaped ? ST_DONE : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = (it_inc == lim_reg) ? ST_DONE : ST_SQ_X;
            end
            ST_DONE:
            begin
                if (load_res)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix.valid)
                begin
                    col_reg <= pix.pixel_col;
                    row_reg <= pix.pixel_row;
                    w_reg   <= w_eff;
                    lim_reg <= lim_eff;
                    it_reg  <= '0;
                    x_reg   <= '0;
                    y_reg   <= '0;
                end
            end
            ST_DIV_RE:
            begin
                if (div_done)
                    c_re_reg <= sat_q(q_ext - SAT_W'(RE_OFFSET));
            end
            ST_DIV_IM:
            begin
                idx_reg <= prod[IDX_W-1:0] + IDX_W'(col_reg);
                if (div_done)
                    c_im_reg <= sat_q(q_ext - SAT_W'(IM_OFFSET));
            end
            ST_SQ_X:
            begin
            end
            ST_SQ_Y:
            begin
                xx_reg <= prod;
            end
            ST_CROSS:
            begin
                diff_reg <= xx_reg - prod;
            end
            ST_UPDATE:
            begin
                x_reg  <= sat_q(re_sum);
                y_reg  <= sat_q(im_sum);
                it_reg <= it_inc;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output stage: hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (load_res)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_index_reg <= idx_reg;
            res_count_reg <= (it_reg == lim_reg) ? '0 : it_reg[COUNT_W-1:0];
        end
    end

    assign pix.ready        = (state_reg == ST_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.pixel_index  = res_index_reg;
    assign res.escape_count = res_count_reg;

endmodule
